[hw/rtl/pke_pkg.sv]
package pke_pkg;

    // Default geometry of the block.
    localparam int NUM_KEYS_DEFAULT  = 96;
    localparam int FRAC_BITS_DEFAULT = 16;

    // Reset values of the configuration registers, Q2.FRAC_BITS.
    localparam int ATTACK_RESET  = 66191;
    localparam int SUSTAIN_RESET = 65470;
    localparam int DECAY_RESET   = 62259;
    localparam int CUTOFF_RESET  = 66;

    // Configuration register indexes.
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_ATTACK  = 2'd0;
    localparam reg_index_t REG_SUSTAIN = 2'd1;
    localparam reg_index_t REG_DECAY   = 2'd2;
    localparam reg_index_t REG_CUTOFF  = 2'd3;

    // Item kinds carried in the input tuser bit.
    localparam logic OP_MIDI = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // MIDI codes.
    localparam logic [7:0] STATUS_NOTE_ON  = 8'd144;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'd128;
    localparam logic [7:0] NOTE_LOW        = 8'd36;
    localparam logic [7:0] NOTE_HIGH       = 8'd107;
    localparam logic [7:0] KEY_OFFSET      = 8'd12;
    localparam logic [7:0] CC_PEDAL        = 8'd64;
    localparam logic [7:0] PEDAL_ON_VALUE  = 8'd127;
    localparam logic [7:0] PEDAL_OFF_VALUE = 8'd0;

    // Peak level is velocity divided by this amount.
    localparam int VELOCITY_DIVISOR = 130;

    // Result field widths.
    localparam int TOTAL_BITS = 25;
    localparam int COUNT_BITS = 7;

    // Envelope phase codes.
    typedef logic [1:0] phase_t;
    localparam phase_t PH_ATTACK  = 2'd0;
    localparam phase_t PH_SUSTAIN = 2'd1;
    localparam phase_t PH_DECAY   = 2'd2;

endpackage

[hw/rtl/pke_ram.sv]
module pke_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pke_mul_unit.sv]
module pke_mul_unit #(
    parameter int LVL_BITS  = pke_pkg::FRAC_BITS_DEFAULT + 2,
    parameter int FRAC_BITS = pke_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [LVL_BITS-1:0] in_level,
    input  logic [LVL_BITS-1:0] in_mult,
    output logic                out_valid,
    output logic [LVL_BITS-1:0] out_level,
    output logic                busy
);

    localparam int PROD_BITS = 2 * LVL_BITS;
    localparam int RND_BITS  = PROD_BITS + 1;
    localparam int SHR_BITS  = RND_BITS - FRAC_BITS;

    logic [PROD_BITS-1:0] prod_reg;
    logic                 prod_vld_reg;
    logic [LVL_BITS-1:0]  level_reg;
    logic                 level_vld_reg;
    logic [RND_BITS-1:0]  rounded;
    logic [SHR_BITS-1:0]  shifted;
    logic                 overflow;

    // Round half up, then drop the fraction; saturate at full scale.
    assign rounded  = RND_BITS'(prod_reg) + (RND_BITS'(1) << (FRAC_BITS - 1));
    assign shifted  = rounded[RND_BITS-1:FRAC_BITS];
    assign overflow = |shifted[SHR_BITS-1:LVL_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            level_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg  <= in_valid;
            level_vld_reg <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_BITS'(in_level) * PROD_BITS'(in_mult);
        level_reg <= overflow ? '1 : shifted[LVL_BITS-1:0];
    end

    assign out_valid = level_vld_reg;
    assign out_level = level_reg;
    assign busy      = prod_vld_reg | level_vld_reg;

endmodule

[hw/rtl/polyphonic_key_envelope.sv]
// Polyphonic key envelope generator.
// Input beats arrive on s_axis_*: tuser = 0 carries one MIDI message in tdata
// (status, first and second data byte), tuser = 1 is one sample tick. A MIDI
// beat gives no result; a tick gives one result beat on m_axis_* with the
// saturated sum of the updated key levels and the number of keys that were
// sounding when the tick began.
// Configuration is written through cfg_write / cfg_index / cfg_data, taken at
// any edge with cfg_write high; write it only while the block is idle.
// Note-on and pedal messages are handled in the cycle they are accepted. A
// note-off that starts a decay passes S_MIDI_RD and S_MIDI_WR (read, modify, write of the key entry).
// A tick walks every key entry through the RAM read port, one key per cycle,
// feeding a single shared multiply-round unit; the walk over the key store is
// followed by a drain of the pipeline before the result is registered.
// s_axis_tready is high only while no item is in progress.
// The result sits in an output register; a stalled receiver delays only the
// end of the next tick, and the block keeps taking MIDI beats meanwhile.
// Reset clears the sounding and held flags, the pedal and the output; the
// key store itself needs no clearing, since a key's stored entry only
// matters once a note-on has written it.
module polyphonic_key_envelope #(
    parameter int NUM_KEYS  = pke_pkg::NUM_KEYS_DEFAULT,
    parameter int FRAC_BITS = pke_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port.
    input  logic                      cfg_write,
    input  pke_pkg::reg_index_t       cfg_index,
    input  logic [FRAC_BITS+1:0]      cfg_data,
    // Input beats.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [23:0]               s_axis_tdata,  // status_byte, data_one, data_two
    input  logic                      s_axis_tuser,  // operation
    // Result beats.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata   // total_level, active_keys
);

    localparam int LVL_BITS  = FRAC_BITS + 2;
    localparam int KEY_BITS  = $clog2(NUM_KEYS);
    localparam int WORD_BITS = LVL_BITS + FRAC_BITS + 2;
    localparam int ACC_BITS  = LVL_BITS + $clog2(NUM_KEYS);
    localparam int SAT_BITS  = (ACC_BITS > pke_pkg::TOTAL_BITS) ? ACC_BITS
                                                                : pke_pkg::TOTAL_BITS;
    localparam int CNT_BITS  = $clog2(NUM_KEYS + 1);
    localparam logic [63:0] PEAK_MAX = (64'd1 << FRAC_BITS) - 64'd1;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_WALK    = 5'b00010,
        S_DRAIN   = 5'b00100,
        S_MIDI_RD = 5'b01000,
        S_MIDI_WR = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [LVL_BITS-1:0] attack_reg, sustain_reg, decay_reg, cutoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= LVL_BITS'(pke_pkg::ATTACK_RESET);
            sustain_reg <= LVL_BITS'(pke_pkg::SUSTAIN_RESET);
            decay_reg   <= LVL_BITS'(pke_pkg::DECAY_RESET);
            cutoff_reg  <= LVL_BITS'(pke_pkg::CUTOFF_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pke_pkg::REG_ATTACK:  attack_reg  <= cfg_data;
                pke_pkg::REG_SUSTAIN: sustain_reg <= cfg_data;
                pke_pkg::REG_DECAY:   decay_reg   <= cfg_data;
                pke_pkg::REG_CUTOFF:  cutoff_reg  <= cfg_data;
            endcase
        end
    end

    // Peak table: velocity * 2^FRAC_BITS / 130, saturated, built at elaboration.
    logic [FRAC_BITS-1:0] peak_tab [256];

    for (genvar v = 0; v < 256; v++)
    begin : g_peak
        localparam logic [63:0] QUOT = (64'(v) << FRAC_BITS) / pke_pkg::VELOCITY_DIVISOR;
        assign peak_tab[v] = FRAC_BITS'((QUOT > PEAK_MAX) ? PEAK_MAX : QUOT);
    end

    // Input decode.
    logic [7:0]          in_status, in_d1, in_d2, note_diff;
    logic                accept, midi_acc, tick_acc, note_hit, note_on, note_off;
    logic [KEY_BITS-1:0] note_key;

    assign in_status = s_axis_tdata[7:0];
    assign in_d1     = s_axis_tdata[15:8];
    assign in_d2     = s_axis_tdata[23:16];
    assign note_diff = in_d1 - pke_pkg::KEY_OFFSET;
    assign note_key  = note_diff[KEY_BITS-1:0];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign midi_acc = accept && (s_axis_tuser == pke_pkg::OP_MIDI);
    assign tick_acc = accept && (s_axis_tuser == pke_pkg::OP_TICK);
    assign note_hit = ((in_status == pke_pkg::STATUS_NOTE_ON)
                       || (in_status == pke_pkg::STATUS_NOTE_OFF))
                      && (in_d1 >= pke_pkg::NOTE_LOW) && (in_d1 <= pke_pkg::NOTE_HIGH)
                      && ({1'b0, note_diff} < 9'(NUM_KEYS));
    assign note_on  = midi_acc && note_hit && (in_status == pke_pkg::STATUS_NOTE_ON);
    assign note_off = midi_acc && note_hit && (in_status == pke_pkg::STATUS_NOTE_OFF);

    // Per-key flags and walk state.
    logic [NUM_KEYS-1:0] held_reg, sounding_reg;
    logic                pedal_reg;
    logic [KEY_BITS-1:0] idx_reg, midi_key_reg;
    logic [ACC_BITS-1:0] acc_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    // Pipeline sideband: B follows the RAM read, C and D follow the unit stages.
    logic                    b_vld_reg, b_held_reg;
    logic [KEY_BITS-1:0]     b_key_reg, c_key_reg, d_key_reg;
    logic                    c_held_reg, d_held_reg;
    logic [FRAC_BITS-1:0]    c_peak_reg, d_peak_reg;
    pke_pkg::phase_t         c_phase_reg, d_phase_reg;

    // Key store: {phase, peak, level}.
    logic                  ram_we;
    logic [KEY_BITS-1:0]   ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;
    logic [LVL_BITS-1:0]   rd_level;
    logic [FRAC_BITS-1:0]  rd_peak;
    pke_pkg::phase_t       rd_phase;

    assign rd_level = ram_rdata[LVL_BITS-1:0];
    assign rd_peak  = ram_rdata[LVL_BITS +: FRAC_BITS];
    assign rd_phase = ram_rdata[WORD_BITS-1 -: 2];

    // Stage B: phase check against the peak and multiplier choice.
    pke_pkg::phase_t     b_phase;
    logic [LVL_BITS-1:0] b_mult;

    assign b_phase = (rd_level > LVL_BITS'(rd_peak)) ? pke_pkg::PH_SUSTAIN : rd_phase;

    always_comb
    begin
        unique case (b_phase)
            pke_pkg::PH_ATTACK:  b_mult = attack_reg;
            pke_pkg::PH_SUSTAIN: b_mult = sustain_reg;
            default:             b_mult = decay_reg;
        endcase
    end

    logic                unit_vld, unit_busy;
    logic [LVL_BITS-1:0] unit_level;

    pke_mul_unit #(
        .LVL_BITS  (LVL_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .in_level  (rd_level),
        .in_mult   (b_mult),
        .out_valid (unit_vld),
        .out_level (unit_level),
        .busy      (unit_busy)
    );

    // Stage D: silence check, release to decay, write-back.
    logic            d_sounding;
    pke_pkg::phase_t d_phase_new;

    assign d_sounding  = unit_level > cutoff_reg;
    assign d_phase_new = (!d_held_reg && !pedal_reg && d_sounding) ? pke_pkg::PH_DECAY
                                                                  : d_phase_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = d_key_reg;
        ram_wdata = {d_phase_new, d_peak_reg, unit_level};
        priority if (unit_vld)
        begin
            ram_we = 1'b1;
        end
        else if (note_on)
        begin
            ram_we    = 1'b1;
            ram_waddr = note_key;
            ram_wdata = {pke_pkg::PH_ATTACK, peak_tab[in_d2], cutoff_reg};
        end
        else if (state_reg == S_MIDI_WR)
        begin
            ram_we    = 1'b1;
            ram_waddr = midi_key_reg;
            ram_wdata = {pke_pkg::PH_DECAY, rd_peak, rd_level};
        end
        else
        begin
            ram_we = 1'b0;
        end
    end

    assign ram_raddr = (state_reg == S_WALK) ? idx_reg : midi_key_reg;

    pke_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_KEYS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result formatting.
    logic [SAT_BITS-1:0]            acc_wide;
    logic [pke_pkg::TOTAL_BITS-1:0] total_sat;
    logic                           out_vld_reg;
    logic [31:0]                    out_data_reg;
    logic                           drain_done;

    assign acc_wide  = SAT_BITS'(acc_reg);
    assign total_sat = (acc_wide > SAT_BITS'({pke_pkg::TOTAL_BITS{1'b1}}))
                       ? '1 : acc_wide[pke_pkg::TOTAL_BITS-1:0];
    assign drain_done = !b_vld_reg && !unit_busy && (!out_vld_reg || m_axis_tready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_acc)
                begin
                    state_next = S_WALK;
                end
                else if (note_off && !pedal_reg)
                begin
                    state_next = S_MIDI_RD;
                end
            end
            S_WALK:
            begin
                if (idx_reg == KEY_BITS'(NUM_KEYS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MIDI_RD: state_next = S_MIDI_WR;
            S_MIDI_WR: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            sounding_reg <= '0;
            pedal_reg    <= 1'b0;
            idx_reg      <= '0;
            b_vld_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // MIDI side: the note action sees the pedal before this message moves it.
            if (note_on)
            begin
                held_reg[note_key]     <= 1'b1;
                sounding_reg[note_key] <= 1'b1;
            end
            if (note_off)
            begin
                held_reg[note_key] <= 1'b0;
            end
            if (midi_acc && (in_d1 == pke_pkg::CC_PEDAL))
            begin
                if (in_d2 == pke_pkg::PEDAL_ON_VALUE)
                begin
                    pedal_reg <= 1'b1;
                end
                else if (in_d2 == pke_pkg::PEDAL_OFF_VALUE)
                begin
                    pedal_reg <= 1'b0;
                end
            end

            // Tick walk.
            if (tick_acc)
            begin
                idx_reg <= '0;
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            b_vld_reg <= 1'b0;
            if (state_reg == S_WALK)
            begin
                b_vld_reg <= sounding_reg[idx_reg];
                if (sounding_reg[idx_reg])
                begin
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                end
                idx_reg <= idx_reg + KEY_BITS'(1);
            end
            if (unit_vld)
            begin
                sounding_reg[d_key_reg] <= d_sounding;
                acc_reg <= acc_reg + ACC_BITS'(unit_level);
            end

            // Output register.
            if ((state_reg == S_DRAIN) && drain_done)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_key_reg   <= idx_reg;
        b_held_reg  <= held_reg[idx_reg];
        c_key_reg   <= b_key_reg;
        c_held_reg  <= b_held_reg;
        c_peak_reg  <= rd_peak;
        c_phase_reg <= b_phase;
        d_key_reg   <= c_key_reg;
        d_held_reg  <= c_held_reg;
        d_peak_reg  <= c_peak_reg;
        d_phase_reg <= c_phase_reg;
        if (note_off)
        begin
            midi_key_reg <= note_key;
        end
        if ((state_reg == S_DRAIN) && drain_done)
        begin
            out_data_reg <= {cnt_reg[pke_pkg::COUNT_BITS-1:0], total_sat};
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // The pipeline is empty whenever a new item can be taken.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!b_vld_reg && !unit_busy))
        else $error("key pipeline busy while idle");

    // Write-back from the unit happens only inside a tick.
    a_writeback_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        unit_vld |-> ((state_reg == S_WALK) || (state_reg == S_DRAIN)))
        else $error("unit result outside a tick");

    // A result appears only at the end of a drain.
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_DRAIN))
        else $error("result without a finished tick");

    // The sounding-key count never passes the number of keys.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(NUM_KEYS))
        else $error("sounding-key count out of range");

endmodule
